@@ rtl/core/ckc_pkg.sv @@
// Shared types, constants and helpers of the canonical k-mer counter.
package ckc_pkg;

  localparam int MAX_KMER_LENGTH = 6;
  localparam int COUNT_WIDTH     = 32;
  localparam int KMER_LEN_W      = 3;
  localparam int KMER_CODE_W     = 12;
  localparam int PADDR_W         = 3;

  localparam logic [KMER_LEN_W-1:0] KMER_LEN_RESET = 3'd3;

  // Register index, taken from paddr[2].
  localparam logic REG_KMER_LENGTH = 1'b0;

  // Operation codes of the command field.
  localparam logic [1:0] CMD_FEED  = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]             command;
    logic [7:0]             base_char;
    logic                   seq_start;
    logic [KMER_CODE_W-1:0] query_kmer;
  } item_t;

  typedef struct packed {
    logic                   kmer_counted;
    logic [KMER_CODE_W-1:0] canonical_kmer;
    logic [COUNT_WIDTH-1:0] count;
    logic                   saturated;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic lookup;
    logic finish;
    logic clear_step;
  } ckc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_clear;
    logic clear_last;
  } ckc_status_t;

  // Returns {is_base, code}; code is A=0, C=1, G=2, T/U=3.
  function automatic logic [2:0] base_code(logic [7:0] ch);
    logic [2:0] r;
    unique case (ch)
      8'h41, 8'h61:               r = 3'b100;
      8'h43, 8'h63:               r = 3'b101;
      8'h47, 8'h67:               r = 3'b110;
      8'h54, 8'h74, 8'h55, 8'h75: r = 3'b111;
      default:                    r = 3'b000;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/canonical_kmer_counter_core.sv @@
// Top level of the canonical k-mer counter: register port, controller and datapath.
//
//   Port group        Direction  Handshake               Payload
//   item              in         item_valid/item_ready   item_t (command, base, query)
//   result            out        result_valid/result_ready result_t (count and key)
//   configuration     in/out     APB psel/penable/pready  kmer_length at byte 0
//
// Each item passes from acceptance to a result by capture of the window and
// canonical key, a registered read of the count memory, and the increment with
// write-back. The counter accepts no new item until the previous one has
// finished. After reset and after every clear command the controller walks
// the whole count memory, one entry per cycle (all 4^MAX_KMER_LENGTH entries,
// 4096 by default), and accepts no item meanwhile. A result that waits in the
// output register does not block the next transfer on the item side; only a
// second finished result waits for it to be taken. Reset is synchronous.
module canonical_kmer_counter_core #(
  parameter int MAX_KMER_LENGTH = ckc_pkg::MAX_KMER_LENGTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  ckc_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output ckc_pkg::result_t            result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ckc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ckc_pkg::*;

  logic [KMER_LEN_W-1:0] kmer_length;
  logic                  reg_write;
  ckc_cmd_t              cmd;
  ckc_status_t           status;

  // The register file holds one register; the word index is paddr[2].
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= KMER_LEN_RESET;
    end else if (reg_write && (paddr[2] == REG_KMER_LENGTH) && (paddr[1:0] == 2'b00)) begin
      kmer_length <= pwdata[KMER_LEN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_KMER_LENGTH) ? 32'(kmer_length) : '0;

  ckc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  ckc_datapath #(
    .MAX_KMER_LENGTH (MAX_KMER_LENGTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .kmer_length (kmer_length),
    .cmd         (cmd),
    .status      (status),
    .result      (result)
  );

`ifndef NO_ASSERTIONS
  // A captured item always goes to the memory read in the next cycle.
  a_capture_then_lookup: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.lookup && !item_ready)
    else $error("capture not followed by lookup");

  // The controller issues at most one datapath command per cycle.
  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.lookup, cmd.finish, cmd.clear_step}))
    else $error("overlapping datapath commands");

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!result_valid || result_ready))
    else $error("result overwritten before transfer");

  // A counted k-mer always reports a nonzero count.
  a_counted_nonzero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kmer_counted) |-> (result.count != '0))
    else $error("counted k-mer with zero count");
`endif

endmodule

@@ rtl/core/ckc_ctrl.sv @@
// Sequencing state machine of the canonical k-mer counter.
module ckc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  output logic                result_valid,
  input  logic                result_ready,
  input  ckc_pkg::ckc_status_t status,
  output ckc_pkg::ckc_cmd_t    cmd
);
  import ckc_pkg::*;

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_LOOKUP = 2'd2;
  localparam logic [1:0] S_UPDATE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_busy;
  logic       out_busy_next;
  logic       out_free;

  assign out_free     = !out_busy || result_ready;
  assign item_ready   = (state == S_IDLE);
  assign result_valid = out_busy;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = status.op_clear ? S_CLEAR : S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    out_busy_next = out_busy && !result_ready;
    if (cmd.finish) begin
      out_busy_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      out_busy <= 1'b0;
    end else begin
      state    <= state_next;
      out_busy <= out_busy_next;
    end
  end

endmodule

@@ rtl/core/ckc_datapath.sv @@
// Windows, canonical key logic, count memory and result register.
module ckc_datapath #(
  parameter int MAX_KMER_LENGTH = ckc_pkg::MAX_KMER_LENGTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ckc_pkg::item_t                     item,
  input  logic [ckc_pkg::KMER_LEN_W-1:0]     kmer_length,
  input  ckc_pkg::ckc_cmd_t                  cmd,
  output ckc_pkg::ckc_status_t               status,
  output ckc_pkg::result_t                   result
);
  import ckc_pkg::*;

  localparam int WIN_W = 2 * MAX_KMER_LENGTH;
  localparam int DEPTH = 1 << WIN_W;
  localparam int KW    = $clog2(MAX_KMER_LENGTH + 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [WIN_W-1:0] fwd;
  logic [WIN_W-1:0] rev;
  logic [KW-1:0]    vb;

  logic [WIN_W-1:0] key;
  logic             op_count;
  logic             op_query;
  logic             op_clear;
  logic [WIN_W-1:0] clr_ptr;

  logic [COUNT_WIDTH-1:0] table_mem [DEPTH];
  logic [COUNT_WIDTH-1:0] rdata;

  logic [KW-1:0]    k_act;
  logic [31:0]      mask32;
  logic [WIN_W-1:0] mask;
  logic [2:0]       decoded;
  logic             is_base;
  logic [1:0]       code;
  logic [WIN_W-1:0] f_base, r_base, f_new, r_new, feed_key;
  logic [KW-1:0]    vb_base, vb_inc;
  logic             counted;
  logic [KW:0]      rev_sh;
  logic [31:0]      q32;
  logic [WIN_W-1:0] qf, rcfull, qr, q_key;
  logic [KW:0]      q_sh;
  logic             is_feed, is_query;

  logic                   mem_we;
  logic [WIN_W-1:0]       mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [31:0]            key32;

  // A length of zero acts as one; lengths past the maximum are clamped.
  always_comb begin
    if (kmer_length == '0) begin
      k_act = KW'(1);
    end else if (32'(kmer_length) > 32'(MAX_KMER_LENGTH)) begin
      k_act = KW'(MAX_KMER_LENGTH);
    end else begin
      k_act = KW'(kmer_length);
    end
  end

  assign mask32  = (32'd1 << {k_act, 1'b0}) - 32'd1;
  assign mask    = mask32[WIN_W-1:0];
  assign decoded = base_code(item.base_char);
  assign is_base = decoded[2];
  assign code    = decoded[1:0];
  assign is_feed  = (item.command == CMD_FEED);
  assign is_query = (item.command == CMD_QUERY);

  // Feed path: a sequence start restarts the window before the base is shifted in.
  always_comb begin
    f_base  = item.seq_start ? '0 : fwd;
    r_base  = item.seq_start ? '0 : rev;
    vb_base = item.seq_start ? '0 : vb;
    rev_sh  = {k_act - KW'(1), 1'b0};
    f_new   = ((f_base << 2) | WIN_W'(code)) & mask;
    r_new   = ((r_base >> 2) | (WIN_W'(~code) << rev_sh)) & mask;
    vb_inc  = (vb_base < k_act) ? vb_base + KW'(1) : vb_base;
    counted = (vb_inc >= k_act);
    feed_key = (f_new < r_new) ? f_new : r_new;
  end

  // Query path: reverse complement over all digits, then drop the unused low ones.
  always_comb begin
    q32    = 32'(item.query_kmer);
    qf     = q32[WIN_W-1:0] & mask;
    rcfull = '0;
    for (int i = 0; i < MAX_KMER_LENGTH; i++) begin
      rcfull[2*(MAX_KMER_LENGTH-1-i) +: 2] = ~qf[2*i +: 2];
    end
    q_sh  = {KW'(MAX_KMER_LENGTH) - k_act, 1'b0};
    qr    = (rcfull >> q_sh) & mask;
    q_key = (qf < qr) ? qf : qr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= '0;
      rev <= '0;
      vb  <= '0;
    end else if (cmd.capture && is_feed) begin
      if (is_base) begin
        fwd <= f_new;
        rev <= r_new;
        vb  <= vb_inc;
      end else begin
        fwd <= '0;
        rev <= '0;
        vb  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_count <= is_feed && is_base && counted;
      op_query <= is_query;
      op_clear <= (item.command == CMD_CLEAR);
      key      <= is_query ? q_key : feed_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (cmd.clear_step) begin
      clr_ptr <= clr_ptr + WIN_W'(1);
    end
  end

  assign count_inc = (rdata == COUNT_MAX) ? rdata : rdata + COUNT_WIDTH'(1);
  assign mem_we    = cmd.clear_step || (cmd.finish && op_count);
  assign mem_waddr = cmd.clear_step ? clr_ptr : key;
  assign mem_wdata = cmd.clear_step ? '0 : count_inc;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.lookup) begin
      rdata <= table_mem[key];
    end
  end

  assign key32 = 32'(key);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.kmer_counted   <= op_count;
      result.canonical_kmer <= (op_count || op_query) ? key32[KMER_CODE_W-1:0] : '0;
      if (op_count) begin
        result.count     <= count_inc;
        result.saturated <= (count_inc == COUNT_MAX);
      end else if (op_query) begin
        result.count     <= rdata;
        result.saturated <= (rdata == COUNT_MAX);
      end else begin
        result.count     <= '0;
        result.saturated <= 1'b0;
      end
    end
  end

  assign status.op_clear   = op_clear;
  assign status.clear_last = &clr_ptr;

endmodule
